// ===== hw/rtl/ecc_pkg.sv =====
// Shared constants, types and floor helpers for the elevator car controller.
package ecc_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int FLOOR_BITS   = 8;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DWELL_W      = 16;
  localparam int PORT_FLOOR_W = 8;
  localparam int PENDING_W    = 5;

  typedef logic [FLOOR_BITS-1:0]   floor_t;
  typedef logic [PORT_FLOOR_W-1:0] port_floor_t;
  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [FILL_W-1:0]       fill_t;
  typedef logic [DWELL_W-1:0]      dwell_t;

  typedef enum logic [1:0] {
    CMD_REQ   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_EMERG = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_MOVING = 2'd2,
    MODE_EMERG  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    HEAD_NONE = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } head_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TRAVEL = 2'd1,
    PH_DOOR   = 2'd2
  } phase_t;

  // Car status after one beat, as loaded into the result register.
  typedef struct packed {
    floor_t car_floor;
    floor_t goal_floor;
    mode_t  mode;
    head_t  heading;
    logic   changed;
  } status_t;

  // Port floor (8 bits) to internal floor width, zero-extended or truncated.
  function automatic floor_t to_floor(port_floor_t f);
    floor_t r;
    r = '0;
    for (int i = 0; i < FLOOR_BITS; i++) begin
      if (i < PORT_FLOOR_W) r[i] = f[i];
    end
    return r;
  endfunction

  function automatic port_floor_t to_port(floor_t f);
    port_floor_t r;
    r = '0;
    for (int i = 0; i < PORT_FLOOR_W; i++) begin
      if (i < FLOOR_BITS) r[i] = f[i];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ecc_queue.sv =====
// Target floor queue: register file with head/tail pointers and fill count.
module ecc_queue import ecc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  floor_t push_a,
  input  floor_t push_b,
  input  logic   pop,
  output floor_t head_floor,
  output logic   not_empty,
  output logic   room2,
  output fill_t  fill_nxt
);

  floor_t mem_r [QUEUE_DEPTH];
  ptr_t   head_r, head_nxt;
  ptr_t   tail_r, tail_nxt;
  ptr_t   tail_p1;
  fill_t  fill_r;

  function automatic ptr_t next_ptr(ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign tail_p1    = next_ptr(tail_r);
  assign head_floor = mem_r[head_r];
  assign not_empty  = (fill_r != '0);
  assign room2      = (fill_r <= FILL_W'(QUEUE_DEPTH - 2));

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push) begin
      tail_nxt = next_ptr(tail_p1);
      fill_nxt = fill_r + FILL_W'(2);
    end else if (pop) begin
      head_nxt = next_ptr(head_r);
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r]  <= push_a;
      mem_r[tail_p1] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room2 && !pop)
    else $error("push without two free slots or together with pop");

  a_pop_filled: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> fill_r == $past(fill_r) - FILL_W'(1))
    else $error("pop did not take one entry");

endmodule

// ===== hw/rtl/ecc_seq.sv =====
// Car sequencer: phase, dwell counter, floor, goal, mode and heading.
module ecc_seq import ecc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    proc,
  input  cmd_t    cmd,
  input  dwell_t  dwell_ticks,
  input  logic    q_avail,
  input  floor_t  q_head,
  output logic    pop,
  output status_t status_nxt
);

  phase_t phase_r, phase_nxt;
  dwell_t dwell_r, dwell_nxt;
  floor_t floor_r, floor_nxt;
  floor_t goal_r, goal_nxt;
  mode_t  mode_r, mode_nxt;
  head_t  head_r, head_nxt;
  logic   changed;

  dwell_t dwell_inc;
  dwell_t dwell_lim;
  logic   dwell_done;
  logic   tick;

  // Ticks only act outside emergency.
  assign tick       = proc && (cmd == CMD_TICK) && (mode_r != MODE_EMERG);
  assign dwell_inc  = dwell_r + DWELL_W'(1);
  assign dwell_lim  = (dwell_ticks == '0) ? DWELL_W'(1) : dwell_ticks;
  assign dwell_done = (dwell_inc >= dwell_lim);
  assign pop        = tick && (phase_r == PH_IDLE) && q_avail;

  always_comb begin
    phase_nxt = phase_r;
    if (tick) begin
      unique case (phase_r)
        PH_IDLE:   if (q_avail) phase_nxt = PH_TRAVEL;
        PH_TRAVEL: if (dwell_done && floor_r == goal_r) phase_nxt = PH_DOOR;
        PH_DOOR:   if (dwell_done) phase_nxt = PH_IDLE;
        default:   phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    dwell_nxt = dwell_r;
    floor_nxt = floor_r;
    goal_nxt  = goal_r;
    mode_nxt  = mode_r;
    head_nxt  = head_r;
    changed   = 1'b0;
    if (proc && cmd == CMD_EMERG) begin
      mode_nxt = (mode_r == MODE_EMERG) ? MODE_CLOSED : MODE_EMERG;
      changed  = 1'b1;
    end else if (tick) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (q_avail) begin
            goal_nxt  = q_head;
            head_nxt  = (q_head > floor_r) ? HEAD_UP : HEAD_DOWN;
            dwell_nxt = '0;
          end
        end
        PH_TRAVEL: begin
          dwell_nxt = dwell_done ? '0 : dwell_inc;
          if (dwell_done) begin
            changed = 1'b1;
            if (floor_r != goal_r) begin
              if (head_r == HEAD_UP) floor_nxt = floor_r + FLOOR_BITS'(1);
              else if (head_r == HEAD_DOWN) floor_nxt = floor_r - FLOOR_BITS'(1);
              mode_nxt = MODE_MOVING;
            end else begin
              mode_nxt = MODE_OPEN;
              head_nxt = HEAD_NONE;
            end
          end
        end
        PH_DOOR: begin
          dwell_nxt = dwell_done ? '0 : dwell_inc;
          if (dwell_done) begin
            changed  = 1'b1;
            mode_nxt = MODE_CLOSED;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status_nxt.car_floor  = floor_nxt;
    status_nxt.goal_floor = goal_nxt;
    status_nxt.mode       = mode_nxt;
    status_nxt.heading    = head_nxt;
    status_nxt.changed    = changed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dwell_r <= '0;
      floor_r <= FLOOR_BITS'(1);
      goal_r  <= FLOOR_BITS'(1);
      mode_r  <= MODE_CLOSED;
      head_r  <= HEAD_NONE;
    end else begin
      phase_r <= phase_nxt;
      dwell_r <= dwell_nxt;
      floor_r <= floor_nxt;
      goal_r  <= goal_nxt;
      mode_r  <= mode_nxt;
      head_r  <= head_nxt;
    end
  end

  a_emerg_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    proc && cmd == CMD_TICK && mode_r == MODE_EMERG |=>
      $stable(phase_r) && $stable(dwell_r) && $stable(floor_r))
    else $error("sequencer moved during emergency");

  a_door_heading: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DOOR |-> head_r == HEAD_NONE)
    else $error("heading set while door phase");

  a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
    floor_r != $past(floor_r) |->
      floor_r == $past(floor_r) + FLOOR_BITS'(1) ||
      floor_r == $past(floor_r) - FLOOR_BITS'(1))
    else $error("car moved more than one floor");

endmodule

// ===== hw/rtl/elevator_car_controller.sv =====
// Top level of the elevator car controller: input stage, queue, sequencer, result register.
//
//  channel | signals                                   | role
//  in      | in_valid/in_ready, command, pickup, dest   | one command beat
//  out     | out_valid/out_ready, status fields         | one status beat per command
//  cfg     | cfg_we, cfg_wdata                          | dwell_ticks register
//
// From acceptance to result each beat passes the input register, then one
// update of queue and sequencer that loads the result register.
// A new beat is accepted every cycle while the result side takes its beats.
// A stalled result holds the pipe; in_ready falls once the input register is full.
// Reset is synchronous on rst_n; the queue storage itself is not cleared.
module elevator_car_controller import ecc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [7:0]            in_pickup_floor,
  input  logic [7:0]            in_dest_floor,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_car_floor,
  output logic [7:0]            out_goal_floor,
  output logic [1:0]            out_car_mode,
  output logic [1:0]            out_heading,
  output logic                  out_changed,
  output logic                  out_request_dropped,
  output logic [PENDING_W-1:0]  out_pending,
  input  logic                  cfg_we,
  input  logic [DWELL_W-1:0]    cfg_wdata
);

  logic        s1_valid_r;
  cmd_t        cmd_r;
  port_floor_t pickup_r;
  port_floor_t dest_r;
  dwell_t      dwell_ticks_r;

  logic        s1_go;
  logic        in_acc;
  logic        push;
  logic        pop;
  logic        room2;
  logic        q_avail;
  floor_t      q_head;
  fill_t       fill_nxt;
  status_t     status_nxt;
  logic        is_req;

  logic        out_valid_r;
  status_t     out_status_r;
  logic        out_drop_r;
  fill_t       out_fill_r;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_acc   = in_valid && in_ready;
  assign is_req   = (cmd_r == CMD_REQ);
  assign push     = s1_go && is_req && room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r <= DWELL_W'(1);
    end else if (cfg_we) begin
      dwell_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= cmd_t'(in_command);
      pickup_r <= in_pickup_floor;
      dest_r   <= in_dest_floor;
    end
  end

  ecc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_a     (to_floor(pickup_r)),
    .push_b     (to_floor(dest_r)),
    .pop        (pop),
    .head_floor (q_head),
    .not_empty  (q_avail),
    .room2      (room2),
    .fill_nxt   (fill_nxt)
  );

  ecc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .proc        (s1_go),
    .cmd         (cmd_r),
    .dwell_ticks (dwell_ticks_r),
    .q_avail     (q_avail),
    .q_head      (q_head),
    .pop         (pop),
    .status_nxt  (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_status_r <= status_nxt;
      out_drop_r   <= is_req && !room2;
      out_fill_r   <= fill_nxt;
    end
  end

  // Pending count is reported in its low bits, zero-extended if narrower.
  always_comb begin
    out_pending = '0;
    for (int i = 0; i < PENDING_W; i++) begin
      if (i < FILL_W) out_pending[i] = out_fill_r[i];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_car_floor       = to_port(out_status_r.car_floor);
  assign out_goal_floor      = to_port(out_status_r.goal_floor);
  assign out_car_mode        = out_status_r.mode;
  assign out_heading         = out_status_r.heading;
  assign out_changed         = out_status_r.changed;
  assign out_request_dropped = out_drop_r;

endmodule

// ===== test/tb_elevator_car_controller.sv =====
// Self-checking testbench for the elevator car controller: directed script, then random traffic.
module tb_elevator_car_controller;
  import ecc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AFTER  = 700;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    port_floor_t            car;
    port_floor_t            goal;
    mode_t                  mode;
    head_t                  heading;
    logic                   changed;
    logic                   dropped;
    logic [PENDING_W-1:0]   pending;
  } car_status_t;

  typedef struct {
    logic [1:0]  cmd;
    port_floor_t pick;
    port_floor_t dest;
    bit          typed;
    car_status_t want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_command;
  logic [7:0]           in_pickup_floor;
  logic [7:0]           in_dest_floor;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_car_floor;
  logic [7:0]           out_goal_floor;
  logic [1:0]           out_car_mode;
  logic [1:0]           out_heading;
  logic                 out_changed;
  logic                 out_request_dropped;
  logic [PENDING_W-1:0] out_pending;
  logic                 cfg_we;
  logic [DWELL_W-1:0]   cfg_wdata;

  elevator_car_controller uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_pickup_floor     (in_pickup_floor),
    .in_dest_floor       (in_dest_floor),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_car_floor       (out_car_floor),
    .out_goal_floor      (out_goal_floor),
    .out_car_mode        (out_car_mode),
    .out_heading         (out_heading),
    .out_changed         (out_changed),
    .out_request_dropped (out_request_dropped),
    .out_pending         (out_pending),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Car model state
  dwell_t      dwell_set;
  floor_t      car_at;
  floor_t      car_goal;
  mode_t       car_md;
  head_t       car_head;
  phase_t      seq_phase;
  dwell_t      dwell_cnt;
  floor_t      targets [QUEUE_DEPTH];
  int          tq_head;
  int          tq_tail;
  int          tq_fill;
  port_floor_t last_target;

  car_status_t status_due [$];
  script_row_t script [$];

  int beats_sent;
  int beats_checked;
  int mismatches;
  int floor_steps;
  int door_cycles;
  int drops_seen;
  int burst_left;
  int quiet_cycles;
  bit hold_done;

  task automatic reset_model();
    dwell_set   = dwell_t'(1);
    car_at      = floor_t'(1);
    car_goal    = floor_t'(1);
    car_md      = MODE_CLOSED;
    car_head    = HEAD_NONE;
    seq_phase   = PH_IDLE;
    dwell_cnt   = '0;
    tq_head     = 0;
    tq_tail     = 0;
    tq_fill     = 0;
    last_target = 8'd1;
    foreach (targets[i]) targets[i] = '0;
  endtask

  function automatic bit dwell_elapsed();
    dwell_t lim;
    lim = (dwell_set == '0) ? dwell_t'(1) : dwell_set;
    dwell_cnt = dwell_cnt + 1'b1;
    if (dwell_cnt >= lim) begin
      dwell_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit tick_sequencer();
    bit chg;
    chg = 1'b0;
    if (car_md != MODE_EMERG) begin
      case (seq_phase)
        PH_IDLE: begin
          if (tq_fill != 0) begin
            car_goal  = targets[tq_head];
            tq_head   = (tq_head + 1) % QUEUE_DEPTH;
            tq_fill   = tq_fill - 1;
            car_head  = (car_goal > car_at) ? HEAD_UP : HEAD_DOWN;
            dwell_cnt = '0;
            seq_phase = PH_TRAVEL;
          end
        end
        PH_TRAVEL: begin
          if (dwell_elapsed()) begin
            if (car_at != car_goal) begin
              if (car_head == HEAD_UP) car_at = car_at + 1'b1;
              else if (car_head == HEAD_DOWN) car_at = car_at - 1'b1;
              car_md = MODE_MOVING;
              floor_steps++;
            end else begin
              car_md    = MODE_OPEN;
              car_head  = HEAD_NONE;
              seq_phase = PH_DOOR;
              door_cycles++;
            end
            chg = 1'b1;
          end
        end
        PH_DOOR: begin
          if (dwell_elapsed()) begin
            car_md    = MODE_CLOSED;
            seq_phase = PH_IDLE;
            chg       = 1'b1;
          end
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
    return chg;
  endfunction

  // Status the car reports after one command beat
  function automatic car_status_t advance_car(logic [1:0] cmd, port_floor_t pick,
                                              port_floor_t dest);
    car_status_t s;
    bit chg;
    bit drop;
    chg  = 1'b0;
    drop = 1'b0;
    case (cmd)
      CMD_REQ: begin
        if (QUEUE_DEPTH - tq_fill >= 2) begin
          targets[tq_tail] = pick;
          tq_tail = (tq_tail + 1) % QUEUE_DEPTH;
          targets[tq_tail] = dest;
          tq_tail = (tq_tail + 1) % QUEUE_DEPTH;
          tq_fill = tq_fill + 2;
          last_target = dest;
        end else begin
          drop = 1'b1;
          drops_seen++;
        end
      end
      CMD_TICK: chg = tick_sequencer();
      CMD_EMERG: begin
        car_md = (car_md == MODE_EMERG) ? MODE_CLOSED : MODE_EMERG;
        chg = 1'b1;
      end
      default: ;
    endcase
    s.car     = car_at;
    s.goal    = car_goal;
    s.mode    = car_md;
    s.heading = car_head;
    s.changed = chg;
    s.dropped = drop;
    s.pending = PENDING_W'(tq_fill);
    return s;
  endfunction

  function automatic car_status_t st(int car, int goal, mode_t m, head_t h, bit chg,
                                     bit drop, int pend);
    car_status_t s;
    s.car     = port_floor_t'(car);
    s.goal    = port_floor_t'(goal);
    s.mode    = m;
    s.heading = h;
    s.changed = chg;
    s.dropped = drop;
    s.pending = PENDING_W'(pend);
    return s;
  endfunction

  task automatic add_row(logic [1:0] cmd, int pick, int dest, bit typed, car_status_t want);
    script_row_t r;
    r.cmd   = cmd;
    r.pick  = port_floor_t'(pick);
    r.dest  = port_floor_t'(dest);
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endtask

  function automatic port_floor_t near_floor(port_floor_t base);
    int v;
    v = $urandom_range(0, 12);
    v = v - 6 + int'(base);
    if (v < 0) v = -v;
    if (v > 255) v = 510 - v;
    return port_floor_t'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] beat %0d: %s got %0d, want %0d", $time, beats_checked, what, got, want);
    mismatches++;
  endtask

  // Sender: bursts of beats separated by random gaps
  task automatic offer(logic [1:0] cmd, port_floor_t pick, port_floor_t dest, bit typed,
                       car_status_t want);
    int idle_cycles;
    car_status_t s;
    if (burst_left == 0) begin
      burst_left  = $urandom_range(1, 24);
      idle_cycles = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
    end else begin
      idle_cycles = 0;
    end
    @(negedge clk);
    if (idle_cycles > 0) begin
      in_valid = 1'b0;
      repeat (idle_cycles) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_command      = cmd;
    in_pickup_floor = pick;
    in_dest_floor   = dest;
    do @(posedge clk); while (!in_ready);
    s = advance_car(cmd, pick, dest);
    status_due.push_back(typed ? want : s);
    beats_sent++;
    burst_left--;
  endtask

  task automatic random_item();
    int roll;
    int req_pct;
    int emerg_pct;
    logic [1:0] cmd;
    port_floor_t pick;
    port_floor_t dest;
    roll      = $urandom_range(0, 99);
    req_pct   = (tq_fill < 8) ? 20 : ((tq_fill < 14) ? 6 : 3);
    emerg_pct = (car_md == MODE_EMERG) ? 15 : 3;
    pick      = port_floor_t'($urandom_range(0, 255));
    dest      = port_floor_t'($urandom_range(0, 255));
    if (roll < req_pct) begin
      cmd = CMD_REQ;
      // keep trips short; an occasional far request stays fully random
      if ($urandom_range(0, 99) != 0) begin
        pick = near_floor(last_target);
        dest = near_floor(pick);
      end
    end else if (roll < req_pct + emerg_pct) begin
      cmd = CMD_EMERG;
    end else if (roll < req_pct + emerg_pct + 2) begin
      cmd = CMD_UNKNOWN;
    end else begin
      cmd = CMD_TICK;
    end
    offer(cmd, pick, dest, 1'b0, '0);
  endtask

  // Register write only once the pipe has drained
  task automatic write_dwell(dwell_t v);
    @(negedge clk);
    in_valid = 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we     = 1'b0;
    dwell_set  = v;
    burst_left = 0;
  endtask

  // Receiver: switches among three stall styles, plus one long hold-off
  initial begin : result_side
    int style;
    int style_left;
    style_left = 0;
    style      = 0;
    out_ready  = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && beats_checked >= HOLD_AFTER) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(20, 80);
      end
      style_left--;
      case (style)
        0:       out_ready = 1'b1;
        1:       out_ready = ($urandom_range(0, 3) != 0);
        default: out_ready = ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    car_status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        report_mismatch("unexpected beat, car_floor", int'(out_car_floor), 0);
      end else begin
        want = status_due.pop_front();
        if (out_car_floor != want.car)
          report_mismatch("car_floor", int'(out_car_floor), int'(want.car));
        if (out_goal_floor != want.goal)
          report_mismatch("goal_floor", int'(out_goal_floor), int'(want.goal));
        if (out_car_mode != want.mode)
          report_mismatch("car_mode", int'(out_car_mode), int'(want.mode));
        if (out_heading != want.heading)
          report_mismatch("heading", int'(out_heading), int'(want.heading));
        if (out_changed != want.changed)
          report_mismatch("changed", int'(out_changed), int'(want.changed));
        if (out_request_dropped != want.dropped)
          report_mismatch("request_dropped", int'(out_request_dropped), int'(want.dropped));
        if (out_pending != want.pending)
          report_mismatch("pending", int'(out_pending), int'(want.pending));
      end
      beats_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT - 1) begin
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin : stimulus
    int phase_dwell [6];
    int phase_items [6];
    int rand_dwell;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_REQ;
    in_pickup_floor = '0;
    in_dest_floor   = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    beats_sent      = 0;
    beats_checked   = 0;
    mismatches      = 0;
    floor_steps     = 0;
    door_cycles     = 0;
    drops_seen      = 0;
    burst_left      = 0;
    quiet_cycles    = 0;
    reset_model();

    add_row(CMD_TICK,    0,   0,   1, st(1, 1, MODE_CLOSED, HEAD_NONE, 0, 0, 0));
    add_row(CMD_UNKNOWN, 255, 255, 1, st(1, 1, MODE_CLOSED, HEAD_NONE, 0, 0, 0));
    add_row(CMD_EMERG,   0,   0,   1, st(1, 1, MODE_EMERG,  HEAD_NONE, 1, 0, 0));
    // request still queues while in emergency; the tick is frozen
    add_row(CMD_REQ,     1,   0,   1, st(1, 1, MODE_EMERG,  HEAD_NONE, 0, 0, 2));
    add_row(CMD_TICK,    0,   0,   1, st(1, 1, MODE_EMERG,  HEAD_NONE, 0, 0, 2));
    add_row(CMD_EMERG,   0,   0,   1, st(1, 1, MODE_CLOSED, HEAD_NONE, 1, 0, 2));
    // target equals car floor: heading down, door opens with no step
    add_row(CMD_TICK,    0,   0,   1, st(1, 1, MODE_CLOSED, HEAD_DOWN, 0, 0, 1));
    add_row(CMD_TICK,    0,   0,   1, st(1, 1, MODE_OPEN,   HEAD_NONE, 1, 0, 1));
    add_row(CMD_TICK,    0,   0,   1, st(1, 1, MODE_CLOSED, HEAD_NONE, 1, 0, 1));
    add_row(CMD_TICK,    0,   0,   1, st(1, 0, MODE_CLOSED, HEAD_DOWN, 0, 0, 0));
    add_row(CMD_TICK,    0,   0,   1, st(0, 0, MODE_MOVING, HEAD_DOWN, 1, 0, 0));
    // emergency in mid-trip, then resume
    add_row(CMD_EMERG,   0,   0,   1, st(0, 0, MODE_EMERG,  HEAD_DOWN, 1, 0, 0));
    add_row(CMD_EMERG,   0,   0,   1, st(0, 0, MODE_CLOSED, HEAD_DOWN, 1, 0, 0));
    add_row(CMD_TICK,    0,   0,   1, st(0, 0, MODE_OPEN,   HEAD_NONE, 1, 0, 0));
    add_row(CMD_REQ,     0,   0,   0, '0);
    add_row(CMD_REQ,     1,   2,   0, '0);
    add_row(CMD_REQ,     3,   2,   0, '0);
    add_row(CMD_REQ,     1,   1,   0, '0);
    add_row(CMD_REQ,     0,   2,   0, '0);
    add_row(CMD_REQ,     4,   3,   0, '0);
    add_row(CMD_REQ,     2,   0,   0, '0);
    add_row(CMD_REQ,     5,   4,   0, '0);
    // queue full: both floors lost
    add_row(CMD_REQ,     255, 0,   1, st(0, 0, MODE_OPEN,   HEAD_NONE, 0, 1, 16));
    add_row(CMD_TICK,    0,   0,   0, '0);
    add_row(CMD_TICK,    0,   0,   0, '0);

    phase_dwell = '{0, 2, 65535, 1, 3, 0};
    phase_items = '{350, 400, 80, 420, 320, 300};
    rand_dwell  = $urandom_range(4, 6);
    phase_dwell[5] = rand_dwell;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) offer(script[i].cmd, script[i].pick, script[i].dest,
                              script[i].typed, script[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      write_dwell(dwell_t'(phase_dwell[ph]));
      repeat (phase_items[ph]) random_item();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d commands and %0d status beats: %0d floor steps,",
             beats_sent, beats_checked, floor_steps);
    $display("%0d door cycles, %0d dropped requests", door_cycles, drops_seen);
    $display("Dwell settings 1, 0, 2, 65535, 1, 3, %0d; one receiver hold-off of %0d cycles",
             rand_dwell, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ecc_pkg.sv
hw/rtl/ecc_queue.sv
hw/rtl/ecc_seq.sv
hw/rtl/elevator_car_controller.sv
test/tb_elevator_car_controller.sv
